// ===== rtl/lfu_cache_lru_tiebreak_assert.svh =====
// Assertion macros used by the cache datapath.
`ifndef LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define LFU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// The expression must never be true outside reset.
`define LFU_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define LFU_ASSERT(lbl, clk, rstn, prop)
`define LFU_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ===== rtl/lfu_pkg.sv =====
// Shared types and constants of the LFU cache.
package lfu_pkg;

  localparam int unsigned CAP_W      = 5;
  localparam int unsigned KEY_PORT_W = 32;
  localparam int unsigned VAL_PORT_W = 32;
  localparam int unsigned STAMP_W    = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_SET = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;    // input transfer taken this cycle
    logic scan_rd;  // read the slot at the scan address
    logic commit;   // apply the update and load the result register
  } lfu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cap_zero;   // effective capacity is zero
    logic last_addr;  // scan address is the last slot
    logic out_free;   // result register can take a new result
  } lfu_sts_t;

endpackage

// ===== rtl/lfu_cache_lru_tiebreak.sv =====
// Top level of the LFU key-value cache with least-recently-used tie-break.
//
//  channel   direction  tdata fields (low bit up)   tuser
//  s_axis    in         key[31:0], value[63:32]      func (0 get, 1 set)
//  m_axis    out        data[31:0]                   found
//  cfg       in         capacity[4:0]                -
//
// An item passes through the accepting cycle, a scan of every slot in turn through
// the single read port of the slot RAM, a drain step that finishes the last compare
// and the commit, which loads the result register. With capacity zero the scan is
// skipped and the item goes from the accepting cycle straight to the commit.
// Reset clears the valid bits, occupancy and access clock at once; slot RAM
// contents need no clearing. The result register lets the next item enter
// while a result waits; a stalled output holds the commit of the next item.
module lfu_cache_lru_tiebreak
  import lfu_pkg::*;
#(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_FREQ    = 255
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [KEY_PORT_W+VAL_PORT_W-1:0]     s_axis_tdata,  // key, value
  input  logic                                 s_axis_tuser,  // func
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [VAL_PORT_W-1:0]                m_axis_tdata,  // data
  output logic                                 m_axis_tuser,  // found
  input  logic                                 cfg_we_i,
  input  logic [CAP_W-1:0]                     cfg_wdata_i
);

  lfu_cmd_t cmd;
  lfu_sts_t sts;

  lfu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfu_dp #(
    .ENTRIES     (ENTRIES),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_FREQ    (MAX_FREQ)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_func_i   (s_axis_tuser),
    .in_key_i    (s_axis_tdata[KEY_PORT_W-1:0]),
    .in_value_i  (s_axis_tdata[KEY_PORT_W+VAL_PORT_W-1:KEY_PORT_W]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_found_o (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== rtl/lfu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lfu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lfu_ctrl.sv =====
// Controller state machine that sequences the slot scan and the commit.
module lfu_ctrl
  import lfu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lfu_sts_t sts_i,
  output lfu_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  state_e state_q;
  logic   ready_q;

  assign in_ready_o     = ready_q;
  assign cmd_o.start    = in_valid_i && ready_q;
  assign cmd_o.scan_rd  = (state_q == ST_SCAN);
  assign cmd_o.commit   = (state_q == ST_COMMIT) && sts_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && ready_q) begin
            ready_q <= 1'b0;
            // With no capacity there is nothing to look at.
            state_q <= sts_i.cap_zero ? ST_COMMIT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (sts_i.last_addr) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== rtl/lfu_dp.sv =====
// Datapath: slot storage, scan trackers, victim choice and result register.
module lfu_dp
  import lfu_pkg::*;
#(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_FREQ    = 255
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lfu_cmd_t              cmd_i,
  output lfu_sts_t              sts_o,
  input  logic                  cfg_we_i,
  input  logic [CAP_W-1:0]      cfg_wdata_i,
  input  logic                  in_func_i,
  input  logic [KEY_PORT_W-1:0] in_key_i,
  input  logic [VAL_PORT_W-1:0] in_value_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  out_found_o,
  output logic [VAL_PORT_W-1:0] out_data_o
);

`include "lfu_cache_lru_tiebreak_assert.svh"

  localparam int unsigned KW = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
  localparam int unsigned VW = (VALUE_WIDTH < VAL_PORT_W) ? VALUE_WIDTH : VAL_PORT_W;
  localparam int unsigned UW = $clog2(MAX_FREQ + 1);
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OW = $clog2(ENTRIES + 1);
  localparam int unsigned CW = (OW > CAP_W) ? OW : CAP_W;
  localparam int unsigned RW = KW + VW + UW + STAMP_W;

  // Slot word layout, from the top: key, value, use count, stamp.
  localparam int unsigned ST_LO = 0;
  localparam int unsigned US_LO = STAMP_W;
  localparam int unsigned VA_LO = STAMP_W + UW;
  localparam int unsigned KE_LO = STAMP_W + UW + VW;

  logic [CAP_W-1:0]   cap_q;
  logic [ENTRIES-1:0] valid_q;
  logic [OW-1:0]      occ_q;
  logic [STAMP_W-1:0] clock_q;

  logic          func_q;
  logic [KW-1:0] key_q;
  logic [VW-1:0] val_q;
  logic          bypass_q;

  logic [AW-1:0] addr_q;
  logic          cmp_valid_q;
  logic [AW-1:0] cmp_idx_q;

  logic          hit_q;
  logic [AW-1:0] hit_idx_q;
  logic [VW-1:0] hit_val_q;
  logic [UW-1:0] hit_uses_q;
  logic          free_q;
  logic [AW-1:0] free_idx_q;
  logic               have_q;
  logic [AW-1:0]      vic_idx_q;
  logic [UW-1:0]      vic_uses_q;
  logic [STAMP_W-1:0] vic_age_q;

  logic                  out_valid_q;
  logic                  out_found_q;
  logic [VAL_PORT_W-1:0] out_data_q;

  // Effective capacity and fullness.
  logic [CW-1:0] cap_ext;
  logic [CW-1:0] cap_eff;
  logic          full;

  assign cap_ext = CW'(cap_q);
  assign cap_eff = (cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext;
  assign full    = CW'(occ_q) >= cap_eff;

  assign sts_o.cap_zero  = (cap_eff == '0);
  assign sts_o.last_addr = (addr_q == AW'(ENTRIES - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Slot read during the scan.
  logic [RW-1:0]      rdata;
  logic [KW-1:0]      r_key;
  logic [VW-1:0]      r_val;
  logic [UW-1:0]      r_uses;
  logic [STAMP_W-1:0] r_stamp;
  logic [STAMP_W-1:0] r_age;
  logic               r_valid;
  logic               take_hit;
  logic               take_free;
  logic               take_vic;

  assign r_key   = rdata[KE_LO +: KW];
  assign r_val   = rdata[VA_LO +: VW];
  assign r_uses  = rdata[US_LO +: UW];
  assign r_stamp = rdata[ST_LO +: STAMP_W];
  assign r_age   = clock_q - r_stamp;
  assign r_valid = valid_q[cmp_idx_q];

  assign take_hit  = cmp_valid_q && r_valid && (r_key == key_q) && !hit_q;
  assign take_free = cmp_valid_q && !r_valid && !free_q;
  // Strict compares keep the lowest slot on equal use counts and ages.
  assign take_vic  = cmp_valid_q && r_valid &&
                     (!have_q || (r_uses < vic_uses_q) ||
                      ((r_uses == vic_uses_q) && (r_age > vic_age_q)));

  // Commit decisions.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [RW-1:0] wr_data;
  logic [UW-1:0] hit_uses_inc;
  logic          ins_en;
  logic          use_free;
  logic          res_found;
  logic [VAL_PORT_W-1:0] res_data;

  assign hit_uses_inc = (hit_uses_q < UW'(MAX_FREQ)) ? hit_uses_q + UW'(1) : hit_uses_q;
  assign use_free     = free_q && !full;

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = hit_idx_q;
    wr_data   = {key_q, val_q, hit_uses_inc, clock_q};
    ins_en    = 1'b0;
    res_found = 1'b0;
    res_data  = '0;
    if (!bypass_q) begin
      if (hit_q) begin
        wr_en     = 1'b1;
        res_found = 1'b1;
        if (func_q == FUNC_GET) begin
          wr_data            = {key_q, hit_val_q, hit_uses_inc, clock_q};
          res_data[VW-1:0]   = hit_val_q;
        end
      end else if (func_q == FUNC_SET) begin
        wr_en   = 1'b1;
        ins_en  = 1'b1;
        wr_addr = use_free ? free_idx_q : vic_idx_q;
        wr_data = {key_q, val_q, UW'(1), clock_q};
      end
    end
  end

  lfu_ram #(
    .WIDTH (RW),
    .DEPTH (ENTRIES)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  // Control state: configuration, valid bits, occupancy, clock, handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      valid_q     <= '0;
      occ_q       <= '0;
      clock_q     <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.start && !sts_o.cap_zero) begin
        clock_q <= clock_q + STAMP_W'(1);
      end
      cmp_valid_q <= cmd_i.scan_rd;
      if (cmd_i.commit && ins_en) begin
        valid_q[wr_addr] <= 1'b1;
        if (use_free) begin
          occ_q <= occ_q + OW'(1);
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers and scan trackers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q   <= in_func_i;
      key_q    <= in_key_i[KW-1:0];
      val_q    <= in_value_i[VW-1:0];
      bypass_q <= sts_o.cap_zero;
      addr_q   <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      have_q   <= 1'b0;
    end else begin
      if (cmd_i.scan_rd && !sts_o.last_addr) begin
        addr_q <= addr_q + AW'(1);
      end
      if (take_hit) begin
        hit_q      <= 1'b1;
        hit_idx_q  <= cmp_idx_q;
        hit_val_q  <= r_val;
        hit_uses_q <= r_uses;
      end
      if (take_free) begin
        free_q     <= 1'b1;
        free_idx_q <= cmp_idx_q;
      end
      if (take_vic) begin
        have_q     <= 1'b1;
        vic_idx_q  <= cmp_idx_q;
        vic_uses_q <= r_uses;
        vic_age_q  <= r_age;
      end
    end
    cmp_idx_q <= addr_q;
    if (cmd_i.commit) begin
      out_found_q <= res_found;
      out_data_q  <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_found_o = out_found_q;
  assign out_data_o  = out_data_q;

  `LFU_ASSERT(a_occ_matches_valid, clk_i, rst_ni, $countones(valid_q) == occ_q)
  `LFU_ASSERT(a_commit_room, clk_i, rst_ni, cmd_i.commit |-> (!out_valid_q || out_ready_i))
  `LFU_ASSERT(a_commit_shows, clk_i, rst_ni, cmd_i.commit |=> out_valid_q)
  `LFU_ASSERT_NEVER(a_scan_and_start, clk_i, rst_ni, cmd_i.start && (cmd_i.scan_rd || cmd_i.commit))

endmodule

// ===== test/tb_lfu_cache_lru_tiebreak.sv =====
// Testbench for the LFU cache: a mirror of the store predicts every reply, stream traffic checks it.
`timescale 1ns / 100ps

localparam int unsigned SLOTS    = 16;
localparam int unsigned MAX_USES = 255;
localparam int unsigned ERR_SHOW = 10;

class cache_mirror;
  bit          live     [SLOTS];
  bit [31:0]   key_mem  [SLOTS];
  bit [31:0]   val_mem  [SLOTS];
  bit [7:0]    use_mem  [SLOTS];
  bit [31:0]   stamp_mem[SLOTS];
  int unsigned fill;
  bit [31:0]   tick;
  bit [4:0]    cap;
  // Each entry is {found, data}.
  bit [32:0]   replies_due[$];
  int unsigned errors;
  int unsigned hit_cnt;
  int unsigned evict_cnt;
  int unsigned sat_cnt;
  int unsigned reply_cnt;

  function new();
    for (int s = 0; s < SLOTS; s++) begin
      live[s] = 1'b0;
    end
    fill = 0;
    tick = '0;
    cap  = lfu_pkg::CAP_RESET;
  endfunction

  function void set_capacity(bit [4:0] c);
    cap = c;
  endfunction

  function int unsigned pending();
    return replies_due.size();
  endfunction

  function void report(string msg);
    errors++;
    if (errors <= ERR_SHOW) begin
      $display("%s", msg);
    end
  endfunction

  // Applies one accepted request to the mirror and queues the reply it must produce.
  function void note_request(bit op, bit [31:0] k, bit [31:0] v);
    int          hit_slot;
    int          slot;
    int          best;
    bit          have;
    bit [7:0]    best_uses;
    bit [31:0]   best_age;
    bit [31:0]   age;
    int unsigned eff;
    bit [32:0]   reply;
    hit_slot = -1;
    reply    = '0;
    eff      = (cap > SLOTS) ? SLOTS : cap;
    if (eff != 0) begin
      tick++;
      for (int s = 0; s < SLOTS; s++) begin
        if (hit_slot < 0 && live[s] && key_mem[s] == k) hit_slot = s;
      end
      if (hit_slot >= 0) begin
        hit_cnt++;
        if (op == lfu_pkg::FUNC_GET) begin
          reply = {1'b1, val_mem[hit_slot]};
        end else begin
          reply = {1'b1, 32'h0};
          val_mem[hit_slot] = v;
        end
        if (use_mem[hit_slot] < MAX_USES) use_mem[hit_slot]++;
        else sat_cnt++;
        stamp_mem[hit_slot] = tick;
      end else if (op == lfu_pkg::FUNC_SET) begin
        slot = -1;
        if (fill < eff) begin
          for (int s = 0; s < SLOTS; s++) begin
            if (slot < 0 && !live[s]) slot = s;
          end
        end
        if (slot < 0) begin
          // Rarest entry goes first; among equal counts the one untouched longest.
          best      = 0;
          have      = 1'b0;
          best_uses = '0;
          best_age  = '0;
          for (int s = 0; s < SLOTS; s++) begin
            if (live[s]) begin
              age = tick - stamp_mem[s];
              if (!have || use_mem[s] < best_uses ||
                  (use_mem[s] == best_uses && age > best_age)) begin
                best      = s;
                best_uses = use_mem[s];
                best_age  = age;
                have      = 1'b1;
              end
            end
          end
          slot = best;
          evict_cnt++;
        end else begin
          fill++;
        end
        live[slot]      = 1'b1;
        key_mem[slot]   = k;
        val_mem[slot]   = v;
        use_mem[slot]   = 8'd1;
        stamp_mem[slot] = tick;
      end
    end
    replies_due.push_back(reply);
  endfunction

  function void check_reply(bit fnd, bit [31:0] d);
    bit [32:0] want;
    reply_cnt++;
    if (replies_due.size() == 0) begin
      report($sformatf("reply %0d: found=%0b data=%h with no request pending",
                       reply_cnt, fnd, d));
      return;
    end
    want = replies_due.pop_front();
    if (want[32] != fnd) begin
      report($sformatf("reply %0d: found expected %0b, got %0b", reply_cnt, want[32], fnd));
    end
    if (want[31:0] != d) begin
      report($sformatf("reply %0d: data expected %h, got %h", reply_cnt, want[31:0], d));
    end
  endfunction
endclass

module tb_lfu_cache_lru_tiebreak;
  import lfu_pkg::*;

  localparam int unsigned POOL       = 40;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned HOLD_LEN   = 300;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [KEY_PORT_W+VAL_PORT_W-1:0] s_axis_tdata;
  logic                         s_axis_tuser;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [VAL_PORT_W-1:0]        m_axis_tdata;
  logic                         m_axis_tuser;
  logic                         cfg_we_i;
  logic [CAP_W-1:0]             cfg_wdata_i;

  cache_mirror mirror = new();
  bit [31:0]   key_pool[POOL];
  bit          hold_req;
  int unsigned burst_left;
  int unsigned items_sent;
  int unsigned cfg_writes;
  int unsigned idle_cycles;

  lfu_cache_lru_tiebreak #(
    .ENTRIES    (SLOTS),
    .KEY_WIDTH  (32),
    .VALUE_WIDTH(32),
    .MAX_FREQ   (MAX_USES)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // key[31:0], value[63:32]
    .s_axis_tuser (s_axis_tuser),   // func
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // data[31:0]
    .m_axis_tuser (m_axis_tuser),   // found
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Reply monitor.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      mirror.check_reply(m_axis_tuser, m_axis_tdata);
    end
  end

  // Watchdog on cycles in which no transfer happens on either stream.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("tb_lfu_cache_lru_tiebreak: errors");
      $finish;
    end
  end

  // Receiver: switches between random stall patterns; a hold request blocks it for a long run.
  initial begin : receiver
    int unsigned mode;
    int unsigned phase_cnt;
    m_axis_tready = 1'b0;
    mode          = 0;
    phase_cnt     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (phase_cnt[5:0] == 0) mode = $urandom_range(0, 3);
      phase_cnt++;
      case (mode)
        0: m_axis_tready = 1'b1;
        1: m_axis_tready = ($urandom_range(0, 1) == 1);
        2: m_axis_tready = (phase_cnt[1:0] == 2'd0);
        default: m_axis_tready = ($urandom_range(0, 6) != 0);
      endcase
    end
  end

  task automatic push_item(bit op, bit [31:0] k, bit [31:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {v, k};
    s_axis_tuser  = op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    mirror.note_request(op, k, v);
    items_sent++;
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain_replies();
    s_axis_tvalid = 1'b0;
    while (mirror.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Every accepted item has replied once the replies drain, so the block is idle when the capacity is written.
  task automatic write_capacity(bit [4:0] c);
    drain_replies();
    repeat (SLOTS + 6) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = c;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    mirror.set_capacity(c);
    cfg_writes++;
  endtask

  task automatic run_phase(bit [4:0] c, int n, bit hot, int hold_at, int pause_at);
    int unsigned pool_n;
    bit          op;
    bit [31:0]   k;
    bit [31:0]   v;
    write_capacity(c);
    pool_n = ((c > SLOTS) ? SLOTS : c) + 3;
    if (pool_n > POOL) pool_n = POOL;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) drain_replies();
      if (hot) begin
        // One key over and over drives its use count into saturation.
        op = (i == 0) || ($urandom_range(0, 9) == 0);
        k  = key_pool[2];
      end else begin
        op = $urandom_range(0, 1);
        k  = ($urandom_range(0, 4) == 0) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
      end
      case ($urandom_range(0, 9))
        0: v = 32'h0;
        1: v = 32'hFFFF_FFFF;
        default: v = $urandom;
      endcase
      push_item(op, k, v);
    end
  endtask

  initial begin : main
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    hold_req      = 1'b0;
    burst_left    = 0;
    items_sent    = 0;
    cfg_writes    = 0;
    key_pool[0]   = 32'h0;
    key_pool[1]   = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL; i++) key_pool[i] = $urandom;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty store, then a first entry at the lowest key.
    push_item(FUNC_GET, 32'h0, 32'hDEAD_BEEF);
    push_item(FUNC_SET, 32'h0, 32'hFFFF_FFFF);
    push_item(FUNC_GET, 32'h0, 32'h0);
    push_item(FUNC_SET, 32'h0, 32'h1234_5678);
    push_item(FUNC_GET, 32'h0, 32'h0);

    // Single entry hammered until its count saturates, with a long output hold on the way.
    run_phase(5'd1, 265, 1'b1, 100, -1);
    // The saturated entry is the only one, so a new key still evicts it.
    push_item(FUNC_SET, key_pool[3], 32'hA5A5_0001);
    push_item(FUNC_GET, key_pool[2], 32'h0);

    write_capacity(5'd16);
    push_item(FUNC_SET, 32'hFFFF_FFFF, 32'h0);
    push_item(FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 1; i <= 14; i++) push_item(FUNC_SET, i, $urandom);
    // Store is full: the oldest of the count-one entries goes.
    push_item(FUNC_SET, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    push_item(FUNC_GET, 32'h1, 32'h0);

    write_capacity(5'd0);
    push_item(FUNC_GET, 32'hFFFF_FFFF, 32'h0);
    push_item(FUNC_SET, 32'h0, 32'hCAFE_F00D);
    write_capacity(5'd31);
    push_item(FUNC_GET, 32'hFFFF_FFFF, 32'h0);
    // Capacity below the current fill: entries stay and inserts replace a victim.
    write_capacity(5'd3);
    push_item(FUNC_SET, 32'h5A5A_5A5A, 32'h0F0F_0F0F);
    push_item(FUNC_GET, 32'h2, 32'h0);

    run_phase(5'd4,  150, 1'b0, -1, 75);
    run_phase(5'd16, 200, 1'b0, 100, -1);
    run_phase(5'd31, 100, 1'b0, -1, -1);
    run_phase(5'd0,   40, 1'b0, -1, -1);
    run_phase(5'd2,  120, 1'b0, -1, 60);
    run_phase(5'd16, 150, 1'b0, -1, -1);

    drain_replies();
    repeat (SLOTS + 8) @(posedge clk_i);
    if (mirror.pending() != 0) begin
      mirror.report($sformatf("%0d replies never arrived", mirror.pending()));
    end
    $display("covered %0d requests over %0d capacity writes: %0d hits, %0d evictions,",
             items_sent, cfg_writes, mirror.hit_cnt, mirror.evict_cnt);
    $display("%0d touches on saturated entries, %0d mismatches", mirror.sat_cnt, mirror.errors);
    if (mirror.errors == 0) begin
      $display("tb_lfu_cache_lru_tiebreak: clean");
    end else begin
      $display("tb_lfu_cache_lru_tiebreak: errors");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/lfu_pkg.sv
rtl/lfu_ram.sv
rtl/lfu_ctrl.sv
rtl/lfu_dp.sv
rtl/lfu_cache_lru_tiebreak.sv
test/tb_lfu_cache_lru_tiebreak.sv
